FILE: hdl/lqm_pkg.sv
// lqm_pkg: shared types and field widths for the linked queue manager
// no dependencies; used by the channel interfaces, the top level and the checker
`default_nettype none

package lqm_pkg;

   localparam int OP_W     = 2;
   localparam int QID_W    = 2;
   localparam int ELEM_W   = 6;
   localparam int STATUS_W = 2;
   localparam int QLEN_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_LINKED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_AP_FLAG,
      S_AP_LINK,
      S_RM_WALK,
      S_RM_FOUND,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/lqm_channels.sv
// lqm_channels: valid/ready channel interfaces for request and response words
// depends on lqm_pkg for the field widths
`default_nettype none

interface lqm_req_if;
   logic                        valid;
   logic                        ready;
   logic [lqm_pkg::OP_W-1:0]    op;
   logic [lqm_pkg::QID_W-1:0]   queue_id;
   logic [lqm_pkg::ELEM_W-1:0]  element;

   modport source (output valid, output op, output queue_id, output element, input ready);
   modport sink   (input valid, input op, input queue_id, input element, output ready);
endinterface

interface lqm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lqm_pkg::STATUS_W-1:0]  status;
   logic [lqm_pkg::QLEN_W-1:0]    queue_length;
   logic [lqm_pkg::ELEM_W-1:0]    head_element;
   logic                          head_valid;

   modport source (output valid, output status, output queue_length, output head_element,
                   output head_valid, input ready);
   modport sink   (input valid, input status, input queue_length, input head_element,
                   input head_valid, output ready);
endinterface

`default_nettype wire

FILE: hdl/linked_queue_manager.sv
// linked_queue_manager: several circular doubly linked queues over one element pool
// depends on lqm_pkg and the channel interfaces in lqm_channels
//
// usage
//   req carries one request word: op (append, remove, query), queue_id, element.
//   rsp carries one response word per request: status, queue_length, head_element,
//   head_valid. both channels move a word when valid and ready are high at a clock edge.
//   one request is worked on at a time; req.ready is high only while the sequencer idles.
// states per request, from idle (accept) through done, which loads the response register;
// the sequencer then returns to idle, where the next request can be accepted
//   query, spare op or remove on an empty queue: dispatch, done
//   append to an empty queue, or of an element already linked: dispatch, flag, done
//   append to a non-empty queue: dispatch, flag, link (flag and tail read, then link writes)
//   remove: dispatch, one walk step per element from the head up to the element, found,
//   done; a remove that finds no such element walks the whole queue, then goes to done.
//   the walk follows the next links one per cycle through one read port, one compare
// reset
//   length counts clear at once; the linked flags sit in a memory that is cleared by a
//   sweep over all NUM_ELEMENTS entries after reset, during which req.ready stays low
// stalls
//   the response sits in an output register; the next request is accepted while it waits.
//   a finished request whose response finds the register still full holds until rsp.ready
`default_nettype none

module linked_queue_manager #(
   parameter int NUM_ELEMENTS = 64,
   parameter int NUM_QUEUES   = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lqm_req_if.sink     req,
   lqm_rsp_if.source   rsp
);

   localparam int IDX_W = $clog2(NUM_ELEMENTS);
   localparam int LEN_W = $clog2(NUM_ELEMENTS + 1);
   localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   // sequencer
   lqm_pkg::state_type state_ff, state_in;

   // latched request word
   logic [lqm_pkg::OP_W-1:0]   op_ff, op_in;
   logic [lqm_pkg::QID_W-1:0]  qid_ff, qid_in;
   logic [lqm_pkg::ELEM_W-1:0] elem_ff, elem_in;

   // per-queue state
   logic [IDX_W-1:0] head_ff   [NUM_QUEUES];
   logic [IDX_W-1:0] head_in   [NUM_QUEUES];
   logic [LEN_W-1:0] length_ff [NUM_QUEUES];
   logic [LEN_W-1:0] length_in [NUM_QUEUES];

   // link and flag memories
   logic [IDX_W-1:0] next_mem [NUM_ELEMENTS];
   logic [IDX_W-1:0] prev_mem [NUM_ELEMENTS];
   logic             flag_mem [NUM_ELEMENTS];

   logic             next_we, prev_we, flag_we;
   logic [IDX_W-1:0] next_waddr, prev_waddr, flag_waddr;
   logic [IDX_W-1:0] next_wdata, prev_wdata;
   logic             flag_wdata;
   logic [IDX_W-1:0] next_raddr, prev_raddr, flag_raddr;
   logic [IDX_W-1:0] next_rd_ff, prev_rd_ff;
   logic             flag_rd_ff;

   // walk and scratch registers
   logic                   walk_first_ff, walk_first_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [IDX_W-1:0]       clr_cnt_ff, clr_cnt_in;
   lqm_pkg::status_type    status_ff, status_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   lqm_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [lqm_pkg::QLEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [lqm_pkg::ELEM_W-1:0]    rsp_head_ff, rsp_head_in;
   logic                          rsp_hvalid_ff, rsp_hvalid_in;

   // decoded request
   logic             q_ok, e_ok;
   logic [QW-1:0]    q_idx;
   logic [IDX_W-1:0] e_idx;
   logic [LEN_W-1:0] len_cur;
   logic [IDX_W-1:0] head_cur;
   logic             len_zero;
   logic [IDX_W-1:0] cur_elem;
   logic             cur_hit, walk_last;
   logic             out_free;

   assign q_ok     = 32'(qid_ff) < NUM_QUEUES;
   assign e_ok     = 32'(elem_ff) < NUM_ELEMENTS;
   assign q_idx    = q_ok ? QW'(qid_ff) : '0;
   assign e_idx    = IDX_W'(elem_ff);
   assign len_cur  = length_ff[q_idx];
   assign head_cur = head_ff[q_idx];
   assign len_zero = (len_cur == '0);

   // the shared compare: current walk position against the target element
   assign cur_elem  = walk_first_ff ? head_cur : next_rd_ff;
   assign cur_hit   = (cur_elem == e_idx);
   assign walk_last = (LEN_W'(cnt_ff + 1'b1) == len_cur);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready        = (state_ff == lqm_pkg::S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.queue_length = rsp_len_ff;
   assign rsp.head_element = rsp_head_ff;
   assign rsp.head_valid   = rsp_hvalid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lqm_pkg::S_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(NUM_ELEMENTS - 1)) state_in = lqm_pkg::S_IDLE;
         end
         lqm_pkg::S_IDLE: begin
            if (req.valid) state_in = lqm_pkg::S_DISPATCH;
         end
         lqm_pkg::S_DISPATCH: begin
            state_in = lqm_pkg::S_DONE;
            if (q_ok) begin
               if (op_ff == lqm_pkg::OP_APPEND && e_ok) begin
                  state_in = lqm_pkg::S_AP_FLAG;
               end else if (op_ff == lqm_pkg::OP_REMOVE && !len_zero && e_ok) begin
                  state_in = lqm_pkg::S_RM_WALK;
               end
            end
         end
         lqm_pkg::S_AP_FLAG: begin
            if (flag_rd_ff || len_zero) state_in = lqm_pkg::S_DONE;
            else                        state_in = lqm_pkg::S_AP_LINK;
         end
         lqm_pkg::S_AP_LINK: begin
            state_in = lqm_pkg::S_DONE;
         end
         lqm_pkg::S_RM_WALK: begin
            if (cur_hit)        state_in = lqm_pkg::S_RM_FOUND;
            else if (walk_last) state_in = lqm_pkg::S_DONE;
         end
         lqm_pkg::S_RM_FOUND: begin
            state_in = lqm_pkg::S_DONE;
         end
         lqm_pkg::S_DONE: begin
            if (out_free) state_in = lqm_pkg::S_IDLE;
         end
         default: state_in = lqm_pkg::S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      op_in         = op_ff;
      qid_in        = qid_ff;
      elem_in       = elem_ff;
      head_in       = head_ff;
      length_in     = length_ff;
      walk_first_in = walk_first_ff;
      cnt_in        = cnt_ff;
      tail_in       = tail_ff;
      clr_cnt_in    = clr_cnt_ff;
      status_in     = status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_hvalid_in = rsp_hvalid_ff;

      next_we    = 1'b0;
      prev_we    = 1'b0;
      flag_we    = 1'b0;
      next_waddr = e_idx;
      prev_waddr = e_idx;
      flag_waddr = e_idx;
      next_wdata = e_idx;
      prev_wdata = e_idx;
      flag_wdata = 1'b0;
      next_raddr = cur_elem;
      prev_raddr = (state_ff == lqm_pkg::S_DISPATCH) ? head_cur : e_idx;
      flag_raddr = e_idx;

      unique case (state_ff)
         lqm_pkg::S_CLEAR: begin
            flag_we    = 1'b1;
            flag_waddr = clr_cnt_ff;
            flag_wdata = 1'b0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         lqm_pkg::S_IDLE: begin
            if (req.valid) begin
               op_in   = req.op;
               qid_in  = req.queue_id;
               elem_in = req.element;
            end
         end
         lqm_pkg::S_DISPATCH: begin
            // flag at the element and tail (prev of head) are read here
            status_in     = lqm_pkg::ST_OK;
            walk_first_in = 1'b1;
            cnt_in        = '0;
            if (!q_ok) begin
               if (op_ff == lqm_pkg::OP_APPEND || op_ff == lqm_pkg::OP_REMOVE) begin
                  status_in = lqm_pkg::ST_EMPTY;
               end
            end else if (op_ff == lqm_pkg::OP_APPEND) begin
               if (!e_ok) status_in = lqm_pkg::ST_ABSENT;
            end else if (op_ff == lqm_pkg::OP_REMOVE) begin
               if (len_zero)   status_in = lqm_pkg::ST_EMPTY;
               else if (!e_ok) status_in = lqm_pkg::ST_ABSENT;
            end
         end
         lqm_pkg::S_AP_FLAG: begin
            if (flag_rd_ff) begin
               status_in = lqm_pkg::ST_LINKED;
            end else begin
               flag_we    = 1'b1;
               flag_wdata = 1'b1;
               if (len_zero) begin
                  // lone element points at itself
                  next_we            = 1'b1;
                  prev_we            = 1'b1;
                  head_in[q_idx]     = e_idx;
                  length_in[q_idx]   = len_cur + 1'b1;
               end else begin
                  next_we    = 1'b1;
                  next_wdata = head_cur;
                  prev_we    = 1'b1;
                  prev_wdata = prev_rd_ff;
                  tail_in    = prev_rd_ff;
               end
            end
         end
         lqm_pkg::S_AP_LINK: begin
            // splice between old tail and head
            next_we          = 1'b1;
            next_waddr       = tail_ff;
            next_wdata       = e_idx;
            prev_we          = 1'b1;
            prev_waddr       = head_cur;
            prev_wdata       = e_idx;
            length_in[q_idx] = len_cur + 1'b1;
         end
         lqm_pkg::S_RM_WALK: begin
            walk_first_in = 1'b0;
            cnt_in        = LEN_W'(cnt_ff + 1'b1);
            if (!cur_hit && walk_last) status_in = lqm_pkg::ST_ABSENT;
         end
         lqm_pkg::S_RM_FOUND: begin
            // next_rd_ff holds next of element, prev_rd_ff its prev
            flag_we          = 1'b1;
            flag_wdata       = 1'b0;
            length_in[q_idx] = len_cur - 1'b1;
            if (len_cur == LEN_W'(1)) begin
               head_in[q_idx] = '0;
            end else begin
               next_we    = 1'b1;
               next_waddr = prev_rd_ff;
               next_wdata = next_rd_ff;
               prev_we    = 1'b1;
               prev_waddr = next_rd_ff;
               prev_wdata = prev_rd_ff;
               if (head_cur == e_idx) head_in[q_idx] = next_rd_ff;
            end
         end
         lqm_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (q_ok) begin
                  rsp_len_in    = lqm_pkg::QLEN_W'(len_cur);
                  rsp_hvalid_in = !len_zero;
                  rsp_head_in   = len_zero ? '0 : lqm_pkg::ELEM_W'(head_cur);
               end else begin
                  rsp_len_in    = '0;
                  rsp_hvalid_in = 1'b0;
                  rsp_head_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_waddr] <= next_wdata;
      next_rd_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
      prev_rd_ff <= prev_mem[prev_raddr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
      flag_rd_ff <= flag_mem[flag_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lqm_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         length_ff    <= length_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      qid_ff        <= qid_in;
      elem_ff       <= elem_in;
      head_ff       <= head_in;
      walk_first_ff <= walk_first_in;
      cnt_ff        <= cnt_in;
      tail_ff       <= tail_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_hvalid_ff <= rsp_hvalid_in;
   end

endmodule

`default_nettype wire

FILE: hdl/lqm_checker.sv
// lqm_checker: port-level assertions for linked_queue_manager, bound to the top level
// depends on lqm_pkg for widths and status codes
`default_nettype none

module lqm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lqm_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [lqm_pkg::QLEN_W-1:0]    rsp_queue_length,
   input wire logic                          rsp_head_valid
);

   // a held response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // nothing offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // head is meaningful exactly when the queue holds elements
   a_head_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_head_valid == (rsp_queue_length != '0)))
      else $error("head_valid disagrees with queue length");

   // empty status only comes with an empty or absent queue
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lqm_pkg::ST_EMPTY) |-> (rsp_queue_length == '0)
         && !rsp_head_valid)
      else $error("empty status with a non-empty queue");

endmodule

bind linked_queue_manager lqm_checker u_lqm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_queue_length (rsp.queue_length),
   .rsp_head_valid   (rsp.head_valid)
);

`default_nettype wire
